@@ src/fwsmh_pkg.sv @@
// Package for the FIFO with sortable min-heap block.
// Holds constants, action and status codes and controller/datapath command types.
package fwsmh_pkg;

   localparam int DEPTH_DEFAULT = 1024;
   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int ACTION_WIDTH = 2;
   localparam int STATUS_WIDTH = 2;
   localparam int POPPED_WIDTH = 32;

   localparam logic [ACTION_WIDTH-1:0] ACT_PUSH = 2'd0;
   localparam logic [ACTION_WIDTH-1:0] ACT_POP  = 2'd1;

   localparam logic [STATUS_WIDTH-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] ST_EMPTY = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] ST_FULL  = 2'd2;

   // Datapath operations issued by the controller.
   typedef enum logic [3:0] {
      OP_NONE,
      OP_PUSH,       // write value at FIFO tail
      OP_FIFO_RD,    // read FIFO head into the FIFO read register
      OP_FIFO_POP,   // latch FIFO read data as result, advance head
      OP_HEAP_RD0,   // read heap root and last entry
      OP_INS_START,  // start an insertion of the moving value
      OP_INS_RD,     // read parent of the insertion hole
      OP_INS_STEP,   // compare with parent, move it down or finish
      OP_REM_START,  // latch root as result and last as the moving value
      OP_REM_RD,     // read both children of the hole
      OP_REM_STEP,   // compare children against moving value
      OP_REM_DONE    // root was the only entry
   } op_type;

   typedef struct packed {
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic fifo_empty;
      logic fifo_full;
      logic heap_empty;
      logic heap_full;
      logic step_done;   // sift loop has finished this cycle
   } stat_type;

endpackage

@@ src/fwsmh_if.sv @@
// Valid/ready channel interface carrying one word of payload.
// Depends on nothing; payload type is a parameter.
interface fwsmh_if #(parameter type PAYLOAD_TYPE = logic) ();
   logic        valid;
   logic        ready;
   PAYLOAD_TYPE payload;
   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

@@ src/fwsmh_datapath.sv @@
// Datapath: FIFO memory, heap memory, pointers and the sift registers.
// Depends on fwsmh_pkg.
module fwsmh_datapath #(
   parameter int DEPTH = fwsmh_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = fwsmh_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  fwsmh_pkg::cmd_type            cmd,
   input  logic [VALUE_WIDTH-1:0]        push_value,
   output fwsmh_pkg::stat_type           stat,
   output logic [VALUE_WIDTH-1:0]        result_value
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [VALUE_WIDTH-1:0] fifo_mem [DEPTH];
   logic [VALUE_WIDTH-1:0] heap_mem [DEPTH];

   logic [AW-1:0] fifo_head_ff, fifo_head_in;
   logic [CW-1:0] fifo_count_ff, fifo_count_in;
   logic [CW-1:0] heap_count_ff, heap_count_in;
   logic [CW-1:0] hole_ff, hole_in;   // current hole index of a sift
   logic [VALUE_WIDTH-1:0] move_ff, move_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;

   logic [VALUE_WIDTH-1:0] fifo_rd_ff;
   logic [VALUE_WIDTH-1:0] heap_rda_ff, heap_rdb_ff;

   logic [AW-1:0] fifo_tail;
   logic [CW:0]   tail_sum;
   logic [AW-1:0] rd_a_addr, rd_b_addr;
   logic          wr_en;
   logic [AW-1:0] wr_addr;
   logic [VALUE_WIDTH-1:0] wr_data;
   logic [CW-1:0] parent, lchild, rchild;
   logic          has_l, has_r, pick_r;
   logic [VALUE_WIDTH-1:0] child_val;
   logic [CW-1:0] child_idx;
   logic          step_done;

   assign tail_sum = {1'b0, fifo_count_ff} + {{(CW+1-AW){1'b0}}, fifo_head_ff};
   assign fifo_tail = (tail_sum >= (CW+1)'(DEPTH)) ? AW'(tail_sum - (CW+1)'(DEPTH))
                                                  : AW'(tail_sum);
   assign parent = (hole_ff - CW'(1)) >> 1;
   assign lchild = CW'({hole_ff, 1'b1});
   assign rchild = CW'({hole_ff, 1'b0} + (CW+1)'(2));
   assign has_l  = ({1'b0, hole_ff, 1'b1} < {2'b0, heap_count_ff});
   assign has_r  = ({1'b0, hole_ff, 1'b0} + (CW+2)'(2) < {2'b0, heap_count_ff});
   assign pick_r = has_r && ($signed(heap_rdb_ff) < $signed(heap_rda_ff));
   assign child_val = pick_r ? heap_rdb_ff : heap_rda_ff;
   assign child_idx = pick_r ? rchild : lchild;

   always_comb begin
      fifo_head_in  = fifo_head_ff;
      fifo_count_in = fifo_count_ff;
      heap_count_in = heap_count_ff;
      hole_in   = hole_ff;
      move_in   = move_ff;
      result_in = result_ff;
      rd_a_addr = fifo_head_ff;
      rd_b_addr = AW'(heap_count_ff - CW'(1));
      wr_en   = 1'b0;
      wr_addr = AW'(hole_ff);
      wr_data = move_ff;
      step_done = 1'b0;
      unique case (cmd.op)
         fwsmh_pkg::OP_PUSH: begin
            fifo_count_in = fifo_count_ff + CW'(1);
         end
         fwsmh_pkg::OP_FIFO_RD: begin
            rd_a_addr = fifo_head_ff;
         end
         fwsmh_pkg::OP_FIFO_POP: begin
            result_in = fifo_rd_ff;
            fifo_head_in = (fifo_head_ff == AW'(DEPTH - 1)) ? '0 : fifo_head_ff + AW'(1);
            fifo_count_in = fifo_count_ff - CW'(1);
         end
         fwsmh_pkg::OP_HEAP_RD0: begin
            rd_a_addr = '0;
            rd_b_addr = AW'(heap_count_ff - CW'(1));
         end
         fwsmh_pkg::OP_INS_START: begin
            // the FIFO head leaves the FIFO and becomes the moving value
            move_in = fifo_rd_ff;
            hole_in = heap_count_ff;
            heap_count_in = heap_count_ff + CW'(1);
            fifo_head_in = (fifo_head_ff == AW'(DEPTH - 1)) ? '0 : fifo_head_ff + AW'(1);
            fifo_count_in = fifo_count_ff - CW'(1);
         end
         fwsmh_pkg::OP_INS_RD: begin
            rd_a_addr = AW'(parent);
         end
         fwsmh_pkg::OP_INS_STEP: begin
            wr_en = 1'b1;
            if (hole_ff != '0 && $signed(move_ff) < $signed(heap_rda_ff)) begin
               wr_data = heap_rda_ff;
               hole_in = parent;
            end else begin
               step_done = 1'b1;
            end
         end
         fwsmh_pkg::OP_REM_START: begin
            result_in = heap_rda_ff;
            move_in = heap_rdb_ff;
            hole_in = '0;
            heap_count_in = heap_count_ff - CW'(1);
         end
         fwsmh_pkg::OP_REM_RD: begin
            rd_a_addr = AW'(lchild);
            rd_b_addr = AW'(rchild);
         end
         fwsmh_pkg::OP_REM_STEP: begin
            wr_en = 1'b1;
            if (has_l && $signed(child_val) < $signed(move_ff)) begin
               wr_data = child_val;
               hole_in = child_idx;
            end else begin
               step_done = 1'b1;
            end
         end
         fwsmh_pkg::OP_REM_DONE: begin
            result_in = heap_rda_ff;
            heap_count_in = heap_count_ff - CW'(1);
         end
         default: ;
      endcase
   end

   // Memories: one write port and registered read ports.
   always_ff @(posedge clock) begin
      if (cmd.op == fwsmh_pkg::OP_PUSH) begin
         fifo_mem[fifo_tail] <= push_value;
      end
      fifo_rd_ff <= fifo_mem[rd_a_addr];
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         heap_mem[wr_addr] <= wr_data;
      end
      heap_rda_ff <= heap_mem[rd_a_addr];
      heap_rdb_ff <= heap_mem[rd_b_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fifo_head_ff  <= '0;
         fifo_count_ff <= '0;
         heap_count_ff <= '0;
      end else begin
         fifo_head_ff  <= fifo_head_in;
         fifo_count_ff <= fifo_count_in;
         heap_count_ff <= heap_count_in;
      end
      hole_ff   <= hole_in;
      move_ff   <= move_in;
      result_ff <= result_in;
   end

   assign stat.fifo_empty = (fifo_count_ff == '0);
   assign stat.fifo_full  = (fifo_count_ff == CW'(DEPTH));
   assign stat.heap_empty = (heap_count_ff == '0);
   assign stat.heap_full  = (heap_count_ff == CW'(DEPTH));
   assign stat.step_done  = step_done;
   assign result_value = result_ff;
endmodule

@@ src/fwsmh_ctrl.sv @@
// Controller state machine: sequences pushes, pops and sorts over the datapath.
// Depends on fwsmh_pkg.
module fwsmh_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [fwsmh_pkg::ACTION_WIDTH-1:0] req_action,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [fwsmh_pkg::STATUS_WIDTH-1:0] rsp_status,
   output logic                    rsp_use_value,
   output fwsmh_pkg::cmd_type      cmd,
   input  fwsmh_pkg::stat_type     stat
);
   typedef enum logic [3:0] {
      S_IDLE, S_FIFO_RD, S_FIFO_POP, S_HEAP_RD, S_REM_START, S_REM_RD, S_REM_STEP,
      S_SORT_CHK, S_SORT_RD, S_INS_START, S_INS_RD, S_INS_STEP, S_RESP
   } state_type;

   state_type state_ff, state_in;
   logic [fwsmh_pkg::STATUS_WIDTH-1:0] status_ff, status_in;
   logic use_ff, use_in;

   always_comb begin
      state_in  = state_ff;
      status_in = status_ff;
      use_in    = use_ff;
      cmd.op    = fwsmh_pkg::OP_NONE;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               status_in = fwsmh_pkg::ST_DONE;
               use_in = 1'b0;
               if (req_action == fwsmh_pkg::ACT_PUSH) begin
                  if (stat.fifo_full) begin
                     status_in = fwsmh_pkg::ST_FULL;
                  end else begin
                     cmd.op = fwsmh_pkg::OP_PUSH;
                  end
                  state_in = S_RESP;
               end else if (req_action == fwsmh_pkg::ACT_POP) begin
                  if (!stat.heap_empty) begin
                     cmd.op = fwsmh_pkg::OP_HEAP_RD0;
                     state_in = S_HEAP_RD;
                  end else if (!stat.fifo_empty) begin
                     cmd.op = fwsmh_pkg::OP_FIFO_RD;
                     state_in = S_FIFO_RD;
                  end else begin
                     status_in = fwsmh_pkg::ST_EMPTY;
                     state_in = S_RESP;
                  end
               end else begin
                  state_in = S_SORT_CHK;
               end
            end
         end
         S_FIFO_RD: begin
            state_in = S_FIFO_POP;
         end
         S_FIFO_POP: begin
            cmd.op = fwsmh_pkg::OP_FIFO_POP;
            use_in = 1'b1;
            state_in = S_RESP;
         end
         S_HEAP_RD: begin
            // Keep the root and last-entry addresses on the read ports.
            cmd.op = fwsmh_pkg::OP_HEAP_RD0;
            use_in = 1'b1;
            state_in = S_REM_START;
         end
         S_REM_START: begin
            if (stat.heap_empty) begin
               state_in = S_RESP;   // never reached; kept safe
            end else begin
               state_in = S_REM_RD;
            end
            // heap of one: root removed with no sift
            cmd.op = fwsmh_pkg::OP_REM_START;
         end
         S_REM_RD: begin
            if (stat.heap_empty) begin
               state_in = S_RESP;
            end else begin
               cmd.op = fwsmh_pkg::OP_REM_RD;
               state_in = S_REM_STEP;
            end
         end
         S_REM_STEP: begin
            cmd.op = fwsmh_pkg::OP_REM_STEP;
            state_in = stat.step_done ? S_RESP : S_REM_RD;
         end
         S_SORT_CHK: begin
            if (stat.fifo_empty || stat.heap_full) begin
               state_in = S_RESP;
            end else begin
               cmd.op = fwsmh_pkg::OP_FIFO_RD;
               state_in = S_SORT_RD;
            end
         end
         S_SORT_RD: begin
            state_in = S_INS_START;
         end
         S_INS_START: begin
            cmd.op = fwsmh_pkg::OP_INS_START;
            state_in = S_INS_RD;
         end
         S_INS_RD: begin
            cmd.op = fwsmh_pkg::OP_INS_RD;
            state_in = S_INS_STEP;
         end
         S_INS_STEP: begin
            cmd.op = fwsmh_pkg::OP_INS_STEP;
            state_in = stat.step_done ? S_SORT_CHK : S_INS_RD;
         end
         S_RESP: begin
            if (rsp_ready) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         status_ff <= fwsmh_pkg::ST_DONE;
         use_ff    <= 1'b0;
      end else begin
         state_ff  <= state_in;
         status_ff <= status_in;
         use_ff    <= use_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);
   assign rsp_status = status_ff;
   assign rsp_use_value = use_ff;
endmodule

@@ src/fifo_with_sortable_min_heap.sv @@
// Top level of the FIFO with sortable min-heap block.
// Depends on fwsmh_pkg, fwsmh_if, fwsmh_ctrl and fwsmh_datapath.
//
// The block holds a FIFO and a binary min-heap of signed values, each DEPTH
// entries deep, and answers every request word with exactly one response word.
// A push appends to the FIFO, or reports status 2 when the FIFO is full. A pop
// returns the heap minimum when the heap is not empty, otherwise the FIFO head,
// or status 1 when both are empty; a heap pop's sift-down walks one heap level
// at a time, with a read state and a compare state per level, over the single
// heap memory. A sort moves FIFO entries into the heap one at a time until the
// FIFO is empty or the heap is full. One request is worked on at a time; the
// next is taken after the response word has been accepted. No clearing pass
// is needed after reset.
module fifo_with_sortable_min_heap #(
   parameter int DEPTH = fwsmh_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = fwsmh_pkg::VALUE_WIDTH_DEFAULT
) (
   input logic clock,
   input logic reset,
   fwsmh_if.sink   req,
   fwsmh_if.source rsp
);
   fwsmh_pkg::cmd_type  cmd;
   fwsmh_pkg::stat_type stat;
   logic [VALUE_WIDTH-1:0] result_value;
   logic [fwsmh_pkg::STATUS_WIDTH-1:0] status;
   logic use_value;
   logic [VALUE_WIDTH-1:0] push_value;
   logic [fwsmh_pkg::POPPED_WIDTH-1:0] popped_ext;

   // Only the low VALUE_WIDTH bits of the pushed word count.
   assign push_value = VALUE_WIDTH'(req.payload.value);

   fwsmh_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req.valid),
      .req_ready     (req.ready),
      .req_action    (req.payload.action),
      .rsp_valid     (rsp.valid),
      .rsp_ready     (rsp.ready),
      .rsp_status    (status),
      .rsp_use_value (use_value),
      .cmd           (cmd),
      .stat          (stat)
   );

   fwsmh_datapath #(.DEPTH(DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .push_value   (push_value),
      .stat         (stat),
      .result_value (result_value)
   );

   // The popped field carries the low 32 bits of the value; zero when no pop.
   always_comb begin
      popped_ext = '0;
      for (int i = 0; i < fwsmh_pkg::POPPED_WIDTH; i++) begin
         if (i < VALUE_WIDTH) begin
            popped_ext[i] = result_value[i];
         end
      end
   end

   assign rsp.payload.status = status;
   assign rsp.payload.popped = use_value ? popped_ext : '0;
endmodule

@@ src/fwsmh_checker.sv @@
// Port-level checker for the FIFO with sortable min-heap block, and its bind.
// Depends on fwsmh_pkg; sees only the top level's ports.
module fwsmh_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [fwsmh_pkg::STATUS_WIDTH-1:0] rsp_status,
   input logic [fwsmh_pkg::POPPED_WIDTH-1:0] rsp_popped
);
   // One request at a time: no request is taken while a response is pending.
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid)) else $error("request taken during response");
   // A response only follows an accepted request.
   a_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready && !req_valid)
                           || $past(rsp_valid)) else $error("spurious response");
   // A failed word carries a zero value.
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != fwsmh_pkg::ST_DONE |-> rsp_popped == '0)
      else $error("nonzero value on failed word");
   // A stalled response holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
                                  && $stable(rsp_popped)) else $error("response changed");
endmodule

bind fifo_with_sortable_min_heap fwsmh_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req.valid),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.payload.status),
   .rsp_popped (rsp.payload.popped)
);

@@ dv/tb_top.sv @@
// Self-checking testbench for fifo_with_sortable_min_heap (push, pop, sort).
// Depends on fwsmh_pkg, fwsmh_if and the block's RTL; drives a directed table,
// then random and fill traffic, and checks every reply against a local model.
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH = fwsmh_pkg::DEPTH_DEFAULT;
   // Any action code other than push or pop sorts; both sort codes are used.
   localparam logic [fwsmh_pkg::ACTION_WIDTH-1:0] ACT_SORT     = 2'd2;
   localparam logic [fwsmh_pkg::ACTION_WIDTH-1:0] ACT_SORT_ALT = 2'd3;
   localparam int RANDOM_WORDS = 180;

   typedef struct packed {
      logic [fwsmh_pkg::ACTION_WIDTH-1:0]        action;
      logic signed [fwsmh_pkg::POPPED_WIDTH-1:0] value;
   } req_word_type;

   typedef struct packed {
      logic [fwsmh_pkg::STATUS_WIDTH-1:0]        status;
      logic signed [fwsmh_pkg::POPPED_WIDTH-1:0] popped;
   } rsp_word_type;

   // One row of the directed table. When has_known is set, the reply is also
   // compared with the value typed into the row.
   typedef struct {
      logic [fwsmh_pkg::ACTION_WIDTH-1:0] action;
      int                                 value;
      bit                                 has_known;
      logic [fwsmh_pkg::STATUS_WIDTH-1:0] status;
      int                                 popped;
   } table_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fwsmh_if #(.PAYLOAD_TYPE(req_word_type)) req_ch ();
   fwsmh_if #(.PAYLOAD_TYPE(rsp_word_type)) rsp_ch ();

   fifo_with_sortable_min_heap uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch.sink),
      .rsp(rsp_ch.source)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Local copy of the block's state, advanced once per accepted request word.
   int fifo_mem[DEPTH];
   int fifo_rd_ptr;
   int fifo_fill;
   int heap_mem[DEPTH];
   int heap_fill;

   rsp_word_type pending_replies[$];
   int error_count;
   int words_sent;
   int replies_seen;
   int full_drops;
   int empty_pops;
   bit no_idle;      // while set, neither side inserts gaps
   int hold_cycles;  // receiver keeps ready low for this many cycles

   task automatic report_mismatch(input string what);
      $display("[%0t] mismatch: %s", $time, what);
      error_count++;
   endtask

   function automatic void heap_put(input int v);
      int slot;
      int parent;
      slot = heap_fill;
      heap_fill++;
      while (slot > 0) begin
         parent = (slot - 1) / 2;
         if (!(v < heap_mem[parent])) break;
         heap_mem[slot] = heap_mem[parent];
         slot = parent;
      end
      heap_mem[slot] = v;
   endfunction

   function automatic int heap_take();
      int top;
      int last;
      int slot;
      int child;
      top = heap_mem[0];
      slot = 0;
      heap_fill--;
      if (heap_fill == 0) return top;
      last = heap_mem[heap_fill];
      forever begin
         child = 2 * slot + 1;
         if (child >= heap_fill) break;
         if (child + 1 < heap_fill && heap_mem[child + 1] < heap_mem[child]) child++;
         if (!(heap_mem[child] < last)) break;
         heap_mem[slot] = heap_mem[child];
         slot = child;
      end
      heap_mem[slot] = last;
      return top;
   endfunction

   function automatic int fifo_take();
      int v;
      v = fifo_mem[fifo_rd_ptr];
      fifo_rd_ptr = (fifo_rd_ptr + 1) % DEPTH;
      fifo_fill--;
      return v;
   endfunction

   // Advances the local state by one request word and returns its reply.
   function automatic rsp_word_type predict_reply(input req_word_type w);
      rsp_word_type r;
      r.status = fwsmh_pkg::ST_DONE;
      r.popped = '0;
      if (w.action == fwsmh_pkg::ACT_PUSH) begin
         if (fifo_fill >= DEPTH) begin
            r.status = fwsmh_pkg::ST_FULL;
         end else begin
            fifo_mem[(fifo_rd_ptr + fifo_fill) % DEPTH] = w.value;
            fifo_fill++;
         end
      end else if (w.action == fwsmh_pkg::ACT_POP) begin
         if (heap_fill > 0) r.popped = heap_take();
         else if (fifo_fill > 0) r.popped = fifo_take();
         else r.status = fwsmh_pkg::ST_EMPTY;
      end else begin
         // A sort stops early once the heap is full; the rest stays queued.
         while (fifo_fill > 0 && heap_fill < DEPTH) heap_put(fifo_take());
      end
      return r;
   endfunction

   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(99);
      if (no_idle || roll < 55) return 0;
      if (roll < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   // Offers one word and returns once it has been accepted. Valid is only
   // lowered when a gap follows, so it never sees two assignments in a step.
   task automatic send_word(input logic [fwsmh_pkg::ACTION_WIDTH-1:0] action,
                            input int value, output rsp_word_type predicted);
      int gap;
      req_word_type w;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      w.action = action;
      w.value = value;
      req_ch.valid <= 1'b1;
      req_ch.payload <= w;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      predicted = predict_reply(w);
      pending_replies = {pending_replies, predicted};
      words_sent++;
   endtask

   // Withdraws the request and waits until every expected reply has come.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_replies.size() != 0) @(posedge clock);
   endtask

   function automatic int pick_value();
      case ($urandom_range(5))
         0: return 32'h7fffffff - $urandom_range(3);
         1: return 32'h80000000 + $urandom_range(3);
         2: return $urandom_range(20) - 10;
         default: return $urandom;
      endcase
   endfunction

   // Response side: random stalls, short mostly and long now and then, plus the
   // long hold-off requested by the stimulus. One assignment per edge.
   int stall_left;
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else if (hold_cycles > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_cycles--;
      end else if (no_idle) begin
         rsp_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else if ($urandom_range(99) < 75) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_ch.ready <= 1'b0;
         stall_left = ($urandom_range(19) == 0) ? $urandom_range(60, 20)
                                                : $urandom_range(2);
      end
   end

   // Every accepted reply word is compared with the oldest prediction.
   always @(posedge clock) begin
      rsp_word_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         replies_seen++;
         if (pending_replies.size() == 0) begin
            report_mismatch($sformatf("reply with nothing expected: status %0d popped %0d",
                                      rsp_ch.payload.status, rsp_ch.payload.popped));
         end else begin
            want = pending_replies.pop_front();
            if (rsp_ch.payload.status !== want.status)
               report_mismatch($sformatf("status %0d, expected %0d",
                                         rsp_ch.payload.status, want.status));
            if (rsp_ch.payload.popped !== want.popped)
               report_mismatch($sformatf("popped %0d, expected %0d",
                                         rsp_ch.payload.popped, want.popped));
            if (want.status == fwsmh_pkg::ST_FULL) full_drops++;
            if (want.status == fwsmh_pkg::ST_EMPTY) empty_pops++;
         end
      end
   end

   table_row_type directed[] = '{
      '{fwsmh_pkg::ACT_POP,  0,            1, fwsmh_pkg::ST_EMPTY, 0},
      '{ACT_SORT,            0,            1, fwsmh_pkg::ST_DONE,  0},
      '{ACT_SORT_ALT,        0,            1, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_PUSH, 32'h7fffffff, 1, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_PUSH, 32'h80000000, 1, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_PUSH, 0,            1, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_PUSH, -1,           1, fwsmh_pkg::ST_DONE,  0},
      // Heap is empty, so the pop takes the FIFO head.
      '{fwsmh_pkg::ACT_POP,  0,            1, fwsmh_pkg::ST_DONE,  32'h7fffffff},
      '{ACT_SORT,            0,            1, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_POP,  0,            1, fwsmh_pkg::ST_DONE,  32'h80000000},
      '{fwsmh_pkg::ACT_PUSH, 32'haaaaaaaa, 0, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_PUSH, 32'h55555555, 0, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_PUSH, 5,            0, fwsmh_pkg::ST_DONE,  0},
      // The heap is drained before anything newer in the FIFO.
      '{fwsmh_pkg::ACT_POP,  0,            0, fwsmh_pkg::ST_DONE,  0},
      '{ACT_SORT_ALT,        0,            0, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_POP,  0,            0, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_POP,  0,            0, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_POP,  0,            0, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_POP,  0,            0, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_POP,  0,            0, fwsmh_pkg::ST_DONE,  0},
      '{fwsmh_pkg::ACT_POP,  0,            1, fwsmh_pkg::ST_EMPTY, 0}
   };

   initial begin
      rsp_word_type got;
      int roll;
      req_ch.valid = 1'b0;
      req_ch.payload = '0;
      rsp_ch.ready = 1'b0;
      fifo_rd_ptr = 0;
      fifo_fill = 0;
      heap_fill = 0;
      error_count = 0;
      no_idle = 0;
      hold_cycles = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) begin
         send_word(directed[i].action, directed[i].value, got);
         if (directed[i].has_known &&
             (got.status !== directed[i].status || got.popped !== directed[i].popped))
            report_mismatch($sformatf("table row %0d predicts %0d/%0d", i,
                                      got.status, got.popped));
      end

      // Random traffic, mostly pushes and pops with occasional sorts so both
      // stores stay shallow and replies are quick.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n == 40) hold_cycles = 300;    // block backs up and stalls requests
         if (n == 100) wait_drained();      // sender pauses until all replies are in
         no_idle = (n >= 120 && n < 160);
         roll = $urandom_range(99);
         if (roll < 50) send_word(fwsmh_pkg::ACT_PUSH, pick_value(), got);
         else if (roll < 85) send_word(fwsmh_pkg::ACT_POP, 0, got);
         else send_word($urandom_range(1) ? ACT_SORT : ACT_SORT_ALT, 0, got);
      end

      // Fill the FIFO past its depth, sort it into a full heap, then check that
      // a sort stops as soon as the heap is full again.
      while (fifo_fill < DEPTH) send_word(fwsmh_pkg::ACT_PUSH, $urandom, got);
      send_word(fwsmh_pkg::ACT_PUSH, $urandom, got);
      send_word(fwsmh_pkg::ACT_PUSH, 32'h7fffffff, got);
      send_word(ACT_SORT, 0, got);
      repeat (40) send_word(fwsmh_pkg::ACT_PUSH, pick_value(), got);
      send_word(ACT_SORT_ALT, 0, got);
      repeat (30) send_word(fwsmh_pkg::ACT_POP, 0, got);
      send_word(ACT_SORT, 0, got);
      repeat (60) send_word(fwsmh_pkg::ACT_POP, 0, got);

      wait_drained();
      repeat (100) @(posedge clock);

      $display("Sent %0d words, checked %0d replies (%0d full-FIFO drops, %0d empty pops).",
               words_sent, replies_seen, full_drops, empty_pops);
      $display("Covered directed extremes, random push/pop/sort, FIFO fill and heap-full sort.");
      if (error_count == 0 && pending_replies.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("Timeout with %0d replies outstanding.", pending_replies.size());
      $display("TB_ERROR");
      $finish;
   end

endmodule
